/* hw/rtl/mat_pkg.sv */
// ----------------------------------------------------------------------------
// mat_pkg
// Types and constants shared by the motion alarm trigger machine.
// ----------------------------------------------------------------------------
package mat_pkg;

    localparam int Q_DEPTH      = 2;
    localparam int TDATA_IN_W   = 104;
    localparam int TDATA_OUT_W  = 48;
    localparam int CFG_ADDR_W   = 3;
    localparam int CFG_DATA_W   = 24;
    localparam logic [19:0] USEC_PER_SEC = 20'd1000000;

    typedef enum logic [1:0] {
        MODE_IDLE      = 2'd0,
        MODE_WAITING   = 2'd1,
        MODE_VIGILANT  = 2'd2,
        MODE_TRIGGERED = 2'd3
    } mode_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_THRESHOLD = 3'd0,
        CFG_NEEDED    = 3'd1,
        CFG_LIFETIME  = 3'd2,
        CFG_PRE       = 3'd3,
        CFG_POST      = 3'd4,
        CFG_MIN_TRIG  = 3'd5,
        CFG_MAX_TRIG  = 3'd6
    } cfg_idx_t;

    typedef enum logic {
        OP_FRAME = 1'b0,
        OP_RESET = 1'b1
    } op_t;

    typedef struct packed {
        logic [23:0] threshold;
        logic [7:0]  needed;
        logic [15:0] lifetime;
        logic [15:0] pre_delay;
        logic [15:0] post_delay;
        logic [15:0] min_trig;
        logic [15:0] max_trig;
    } cfg_t;

    // classified word handed from front to back
    typedef struct packed {
        op_t         op;
        logic        motion;
        logic [31:0] now_sec;
        logic [47:0] now_usec;
        logic [32:0] at_pre;
        logic [32:0] at_post;
        logic [32:0] at_min;
        logic [32:0] at_max;
    } item_t;

    typedef struct packed {
        mode_t       mode;
        logic [7:0]  frames;
        logic [32:0] end_sec;
    } result_t;

endpackage

/* hw/rtl/mat_front.sv */
// ----------------------------------------------------------------------------
// mat_front
// Accepts input words, flags motion and precomputes the time sums.
// ----------------------------------------------------------------------------
module mat_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  mat_pkg::cfg_t               cfg,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [mat_pkg::TDATA_IN_W-1:0] s_tdata,
    input  logic                        s_tuser,
    output logic                        f_valid,
    input  logic                        f_ready,
    output mat_pkg::item_t              f_item
);
    import mat_pkg::*;

    logic  f_valid_reg, f_valid_next;
    item_t f_item_reg, f_item_next;
    logic  s_acc;

    logic [31:0] now;
    logic [47:0] usec;
    logic [23:0] level;

    assign now   = s_tdata[31:0];
    assign usec  = s_tdata[79:32];
    assign level = s_tdata[103:80];

    assign s_tready = !f_valid_reg || f_ready;
    assign s_acc    = s_tvalid && s_tready;

    always_comb begin
        f_item_next.op       = op_t'(s_tuser);
        f_item_next.motion   = level > cfg.threshold;
        f_item_next.now_sec  = now;
        f_item_next.now_usec = usec;
        f_item_next.at_pre   = {1'b0, now} + {17'b0, cfg.pre_delay};
        f_item_next.at_post  = {1'b0, now} + {17'b0, cfg.post_delay};
        f_item_next.at_min   = {1'b0, now} + {17'b0, cfg.min_trig};
        f_item_next.at_max   = {1'b0, now} + {17'b0, cfg.max_trig};
        f_valid_next         = s_acc || (f_valid_reg && !f_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
        end else begin
            f_valid_reg <= f_valid_next;
        end
        if (s_acc) begin
            f_item_reg <= f_item_next;
        end
    end

    assign f_valid = f_valid_reg;
    assign f_item  = f_item_reg;

endmodule

/* hw/rtl/mat_queue.sv */
// ----------------------------------------------------------------------------
// mat_queue
// Short first-in first-out buffer between front and back.
// ----------------------------------------------------------------------------
module mat_queue #(
    parameter int DEPTH = mat_pkg::Q_DEPTH
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    output logic           push_ready,
    input  mat_pkg::item_t push_item,
    output logic           pop_valid,
    input  logic           pop,
    output mat_pkg::item_t pop_item
);
    import mat_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

    item_t             entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_reg, wr_next;
    logic [PTR_W-1:0]  rd_reg, rd_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    assign push_ready = cnt_reg != FULL;
    assign pop_valid  = cnt_reg != '0;
    assign pop_item   = entry_reg[rd_reg];

    always_comb begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push) begin
            wr_next = (wr_reg == LAST) ? '0 : wr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_next = (rd_reg == LAST) ? '0 : rd_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
        if (push) begin
            entry_reg[wr_reg] <= push_item;
        end
    end

endmodule

/* hw/rtl/mat_back.sv */
// ----------------------------------------------------------------------------
// mat_back
// Alarm state machine and timers; one word per cycle into the result register unless the output stalls.
// ----------------------------------------------------------------------------
module mat_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  mat_pkg::cfg_t                   cfg,
    input  logic                            q_valid,
    output logic                            q_pop,
    input  mat_pkg::item_t                  q_item,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [mat_pkg::TDATA_OUT_W-1:0] m_tdata
);
    import mat_pkg::*;

    mode_t       mode_reg, mode_next;
    logic [7:0]  frames_reg, frames_next;
    logic [32:0] may_reg, may_next;
    logic [31:0] start_reg, start_next;
    logic [32:0] seg_reg, seg_next;
    logic [47:0] ws_reg, ws_next;
    logic [35:0] lim_reg;
    logic        o_valid_reg, o_valid_next;
    result_t     o_res_reg, o_res_next;

    logic [47:0] ws_eff, elapsed;
    logic        in_win, fire, expired;
    logic [7:0]  frames_inc;
    logic [32:0] cap, end_now;

    assign q_pop = q_valid && (!o_valid_reg || m_tready);

    always_comb begin
        ws_eff     = (frames_reg == '0) ? q_item.now_usec : ws_reg;
        elapsed    = q_item.now_usec - ws_eff;
        in_win     = elapsed < {12'b0, lim_reg};
        frames_inc = (frames_reg == 8'hFF) ? frames_reg : frames_reg + 8'd1;
        fire       = frames_inc >= cfg.needed;
        expired    = {1'b0, q_item.now_sec} > seg_reg;
        cap        = {1'b0, start_reg} + {17'b0, cfg.max_trig};
        end_now    = (q_item.at_min < cap) ? q_item.at_min : cap;
    end

    // next state
    always_comb begin
        mode_next = mode_reg;
        if (q_item.op == OP_RESET) begin
            mode_next = MODE_IDLE;
        end else begin
            unique case (mode_reg)
                MODE_IDLE: begin
                    mode_next = MODE_WAITING;
                end
                MODE_WAITING: begin
                    if ({1'b0, q_item.now_sec} > may_reg) mode_next = MODE_VIGILANT;
                end
                MODE_VIGILANT: begin
                    if (q_item.motion && in_win && fire) mode_next = MODE_TRIGGERED;
                end
                MODE_TRIGGERED: begin
                    if (expired) mode_next = MODE_WAITING;
                end
            endcase
        end
    end

    // timers and counters
    always_comb begin
        frames_next = frames_reg;
        may_next    = may_reg;
        start_next  = start_reg;
        seg_next    = seg_reg;
        ws_next     = ws_reg;
        if (q_item.op == OP_RESET) begin
            frames_next = '0;
            may_next    = '0;
            start_next  = '0;
            seg_next    = '0;
            ws_next     = '0;
        end else begin
            unique case (mode_reg)
                MODE_IDLE: begin
                    may_next = q_item.at_pre;
                end
                MODE_WAITING: begin
                end
                MODE_VIGILANT: begin
                    if (q_item.motion) begin
                        if (in_win) begin
                            if (fire) begin
                                frames_next = '0;
                                ws_next     = '0;
                                start_next  = q_item.now_sec;
                                seg_next    = (q_item.at_min < q_item.at_max) ?
                                              q_item.at_min : q_item.at_max;
                            end else begin
                                frames_next = frames_inc;
                                ws_next     = ws_eff;
                            end
                        end else begin
                            frames_next = '0;
                            ws_next     = '0;
                            seg_next    = '0;
                        end
                    end
                end
                MODE_TRIGGERED: begin
                    if (expired) begin
                        may_next = q_item.at_post;
                    end else if (q_item.motion) begin
                        seg_next = end_now;
                    end
                end
            endcase
        end
        o_res_next.mode    = mode_next;
        o_res_next.frames  = frames_next;
        o_res_next.end_sec = seg_next;
        o_valid_next       = q_pop || (o_valid_reg && !m_tready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= MODE_IDLE;
            frames_reg  <= '0;
            may_reg     <= '0;
            start_reg   <= '0;
            seg_reg     <= '0;
            ws_reg      <= '0;
            o_valid_reg <= 1'b0;
        end else begin
            o_valid_reg <= o_valid_next;
            if (q_pop) begin
                mode_reg   <= mode_next;
                frames_reg <= frames_next;
                may_reg    <= may_next;
                start_reg  <= start_next;
                seg_reg    <= seg_next;
                ws_reg     <= ws_next;
            end
        end
        lim_reg <= 36'(cfg.lifetime) * 36'(USEC_PER_SEC);
        if (q_pop) begin
            o_res_reg <= o_res_next;
        end
    end

    assign m_tvalid = o_valid_reg;
    assign m_tdata  = {5'b0, o_res_reg.end_sec, o_res_reg.frames, o_res_reg.mode};

endmodule

/* hw/rtl/motion_alarm_trigger_fsm_unit.sv */
// ----------------------------------------------------------------------------
// motion_alarm_trigger_fsm_unit
// Motion alarm trigger machine with configuration register bank.
// ----------------------------------------------------------------------------
// A word passes the front register, the queue and the result register.
// Throughput: one word per cycle unless the result side stalls.
// A two-entry queue lets the input side run on while the result side stalls.
// Reset (aresetn low, synchronous) clears the machine and loads register
// defaults; written configuration is registered before it takes effect.
module motion_alarm_trigger_fsm_unit #(
    parameter int QUEUE_DEPTH = mat_pkg::Q_DEPTH
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // now_sec[31:0], now_usec[79:32], motion_level[103:80]
    input  logic [mat_pkg::TDATA_IN_W-1:0]  s_tdata,
    // op
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // mode[1:0], frames_counted[9:2], trigger_end_sec[42:10], zero fill
    output logic [mat_pkg::TDATA_OUT_W-1:0] m_tdata,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [mat_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [mat_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import mat_pkg::*;

    cfg_t  cfg_reg, cfg_next;
    logic  f_valid, f_ready, q_valid, q_pop;
    item_t f_item, q_item;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_idx_t'(cfg_addr))
                CFG_THRESHOLD: cfg_next.threshold  = cfg_data;
                CFG_NEEDED:    cfg_next.needed     = cfg_data[7:0];
                CFG_LIFETIME:  cfg_next.lifetime   = cfg_data[15:0];
                CFG_PRE:       cfg_next.pre_delay  = cfg_data[15:0];
                CFG_POST:      cfg_next.post_delay = cfg_data[15:0];
                CFG_MIN_TRIG:  cfg_next.min_trig   = cfg_data[15:0];
                CFG_MAX_TRIG:  cfg_next.max_trig   = cfg_data[15:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.threshold  <= 24'd1000;
            cfg_reg.needed     <= 8'd3;
            cfg_reg.lifetime   <= 16'd1;
            cfg_reg.pre_delay  <= 16'd0;
            cfg_reg.post_delay <= 16'd0;
            cfg_reg.min_trig   <= 16'd5;
            cfg_reg.max_trig   <= 16'd60;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    mat_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .f_valid  (f_valid),
        .f_ready  (f_ready),
        .f_item   (f_item)
    );

    mat_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (f_valid && f_ready),
        .push_ready (f_ready),
        .push_item  (f_item),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_item   (q_item)
    );

    mat_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_item   (q_item),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

/* hw/rtl/mat_checker.sv */
// ----------------------------------------------------------------------------
// mat_checker
// Port-level checks on the result stream of the alarm machine.
// ----------------------------------------------------------------------------
module mat_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [mat_pkg::TDATA_OUT_W-1:0] m_tdata
);
    import mat_pkg::*;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid straight after reset");

    // idle only follows a stream reset, which clears everything
    a_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1:0] == MODE_IDLE |-> m_tdata[42:2] == '0)
        else $error("idle word with non-zero count or end time");

    // the frame count lives only while vigilant
    a_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1:0] != MODE_VIGILANT |-> m_tdata[9:2] == '0)
        else $error("frame count outside vigilant mode");

endmodule

bind motion_alarm_trigger_fsm_unit mat_checker u_mat_checker (.*);

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the motion alarm trigger machine. A short table of
// frames walks the idle, waiting, vigilant and triggered states under the
// reset configuration. Randomised phases follow, each with its own register
// settings, and feed frame sequences with noise and stream resets. Every
// result word is checked against a typed table row or a cycle-free model.
// ----------------------------------------------------------------------------
module tb_top;
    import mat_pkg::*;

    localparam int PHASES       = 14;
    localparam int PHASE_FRAMES = 125;
    localparam int STALL_LIMIT  = 5000;
    localparam int SETTLE_CYC   = 4;
    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE = 3'd7;

    typedef struct packed {
        logic        op;
        logic [31:0] sec;
        logic [47:0] usec;
        logic [23:0] level;
        logic        typed;
        result_t     want;
    } frame_row_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [TDATA_IN_W-1:0]  s_tdata   = '0;
    logic                   s_tuser   = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [TDATA_OUT_W-1:0] m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_ADDR_W-1:0]  cfg_addr  = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    // model state
    cfg_t        cfg_shadow;
    mode_t       alarm_mode;
    logic [7:0]  hit_count;
    logic [32:0] wake_at;
    logic [31:0] trig_start;
    logic [32:0] seg_end;
    logic [47:0] win_start_us;

    result_t     status_due[$];
    frame_row_t  frame_table[$];
    int          fail_count = 0;
    bit          tx_calm    = 1'b0;
    bit          rx_calm    = 1'b0;
    int          rx_hold    = 0;

    motion_alarm_trigger_fsm_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic int pick_gap(input bit calm);
        int r;
        if (calm) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 50) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [32:0] capped_end(input logic [31:0] now);
        logic [32:0] by_motion;
        logic [32:0] by_cap;
        by_motion = 33'(now) + 33'(cfg_shadow.min_trig);
        by_cap    = 33'(trig_start) + 33'(cfg_shadow.max_trig);
        return (by_motion < by_cap) ? by_motion : by_cap;
    endfunction

    task automatic advance_alarm(input op_t op, input logic [31:0] now,
                                 input logic [47:0] usec, input logic [23:0] level,
                                 output result_t res);
        logic        moving;
        logic [47:0] span_us;
        logic [47:0] elapsed;
        moving  = level > cfg_shadow.threshold;
        span_us = 48'(cfg_shadow.lifetime) * 48'(USEC_PER_SEC);
        if (op == OP_RESET) begin
            alarm_mode   = MODE_IDLE;
            hit_count    = '0;
            wake_at      = '0;
            trig_start   = '0;
            seg_end      = '0;
            win_start_us = '0;
        end else begin
            case (alarm_mode)
                MODE_IDLE: begin
                    wake_at    = 33'(now) + 33'(cfg_shadow.pre_delay);
                    alarm_mode = MODE_WAITING;
                end
                MODE_WAITING: begin
                    if (33'(now) > wake_at) begin
                        alarm_mode = MODE_VIGILANT;
                    end
                end
                MODE_VIGILANT: begin
                    if (moving) begin
                        if (hit_count == 8'd0) begin
                            win_start_us = usec;
                        end
                        elapsed = usec - win_start_us;
                        if (elapsed < span_us) begin
                            if (hit_count != 8'hFF) begin
                                hit_count = hit_count + 8'd1;
                            end
                            if (hit_count >= cfg_shadow.needed) begin
                                hit_count    = '0;
                                win_start_us = '0;
                                trig_start   = now;
                                seg_end      = capped_end(now);
                                alarm_mode   = MODE_TRIGGERED;
                            end
                        end else begin
                            // window expired: start over on the next motion frame
                            win_start_us = '0;
                            seg_end      = '0;
                            hit_count    = '0;
                        end
                    end
                end
                default: begin
                    if (33'(now) > seg_end) begin
                        wake_at    = 33'(now) + 33'(cfg_shadow.post_delay);
                        alarm_mode = MODE_WAITING;
                    end else if (moving) begin
                        seg_end = capped_end(now);
                    end
                end
            endcase
        end
        res.mode    = alarm_mode;
        res.frames  = hit_count;
        res.end_sec = seg_end;
    endtask

    task automatic note_failure(input string msg);
        if (fail_count < 10) begin
            $display("%0t: %s", $realtime, msg);
        end
        fail_count++;
    endtask

    task automatic send_word(input op_t op, input logic [31:0] sec,
                             input logic [47:0] usec, input logic [23:0] level,
                             input bit typed, input result_t want);
        int      gap;
        result_t due;
        if ($urandom_range(0, 49) == 0) begin
            tx_calm = !tx_calm;
        end
        gap = pick_gap(tx_calm);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {level, usec, sec};
        do @(posedge aclk); while (!s_tready);
        advance_alarm(op, sec, usec, level, due);
        status_due.push_back(typed ? want : due);
    endtask

    // leaves cfg_valid high; the caller drops it after the last write
    task automatic cfg_write(input logic [CFG_ADDR_W-1:0] idx, input logic [23:0] data);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_THRESHOLD: cfg_shadow.threshold  = data;
            CFG_NEEDED:    cfg_shadow.needed     = data[7:0];
            CFG_LIFETIME:  cfg_shadow.lifetime   = data[15:0];
            CFG_PRE:       cfg_shadow.pre_delay  = data[15:0];
            CFG_POST:      cfg_shadow.post_delay = data[15:0];
            CFG_MIN_TRIG:  cfg_shadow.min_trig   = data[15:0];
            CFG_MAX_TRIG:  cfg_shadow.max_trig   = data[15:0];
            default: ;
        endcase
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (status_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);
    endtask

    function automatic logic [15:0] pick_delay(input int top);
        case ($urandom_range(0, 5))
            0:       return 16'd0;
            1:       return 16'd1;
            2:       return 16'hFFFF;
            default: return 16'($urandom_range(2, top));
        endcase
    endfunction

    task automatic configure_phase(input int p);
        logic [23:0] thr;
        logic [7:0]  need;
        logic [15:0] life;
        logic [15:0] pre;
        logic [15:0] post;
        logic [15:0] tmin;
        logic [15:0] tmax;
        logic [23:0] junk;
        case (p)
            0: begin
                thr = 24'd1000; need = 8'd3; life = 16'd1;
                pre = '0; post = '0; tmin = 16'd5; tmax = 16'd60;
            end
            1: begin
                thr = 24'hFFFFFF; need = 8'hFF; life = 16'hFFFF;
                pre = 16'hFFFF; post = 16'hFFFF; tmin = 16'hFFFF; tmax = 16'hFFFF;
            end
            2: begin
                thr = '0; need = '0; life = '0;
                pre = '0; post = '0; tmin = '0; tmax = '0;
            end
            default: begin
                case ($urandom_range(0, 4))
                    0:       thr = '0;
                    1:       thr = 24'd1000;
                    2:       thr = 24'hFFFFFF;
                    3:       thr = 24'($urandom_range(0, 5000));
                    default: thr = 24'($urandom);
                endcase
                case ($urandom_range(0, 9))
                    0:       need = '0;
                    1:       need = 8'd1;
                    2:       need = 8'hFF;
                    default: need = 8'($urandom_range(2, 6));
                endcase
                case ($urandom_range(0, 7))
                    0:       life = '0;
                    1:       life = 16'hFFFF;
                    default: life = 16'($urandom_range(1, 4));
                endcase
                pre  = pick_delay(8);
                post = pick_delay(8);
                tmin = pick_delay(12);
                tmax = pick_delay(30);
            end
        endcase
        if (p == 3) begin
            need = '0;
            life = 16'd1;
        end
        // upper bits beyond each register's width must be dropped
        junk = (p > 2 && $urandom_range(0, 2) == 0) ? 24'($urandom) : 24'd0;
        cfg_write(CFG_THRESHOLD, thr);
        cfg_write(CFG_NEEDED,    {junk[23:8], need});
        cfg_write(CFG_LIFETIME,  {junk[23:16], life});
        cfg_write(CFG_PRE,       {junk[23:16], pre});
        cfg_write(CFG_POST,      {junk[23:16], post});
        cfg_write(CFG_MIN_TRIG,  {junk[23:16], tmin});
        cfg_write(CFG_MAX_TRIG,  {junk[23:16], tmax});
        if ($urandom_range(0, 2) == 0) begin
            cfg_write(CFG_SPARE, 24'($urandom));
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [23:0] pick_level(input bit want_motion);
        logic [23:0] thr;
        thr = cfg_shadow.threshold;
        if (want_motion && thr != 24'hFFFFFF) begin
            if ($urandom_range(0, 3) == 0) begin
                return thr + 24'd1;
            end
            return 24'($urandom_range(32'(thr) + 1, 32'hFFFFFF));
        end
        if ($urandom_range(0, 4) == 0) begin
            return thr;
        end
        return 24'($urandom_range(0, 32'(thr)));
    endfunction

    task automatic add_row(input op_t op, input logic [31:0] sec, input logic [47:0] usec,
                           input logic [23:0] level, input bit typed, input mode_t mode,
                           input logic [7:0] frames, input logic [32:0] end_sec);
        frame_row_t row;
        row.op           = op;
        row.sec          = sec;
        row.usec         = usec;
        row.level        = level;
        row.typed        = typed;
        row.want.mode    = mode;
        row.want.frames  = frames;
        row.want.end_sec = end_sec;
        frame_table.push_back(row);
    endtask

    // result side: random back-pressure
    always @(posedge aclk) begin
        if ($urandom_range(0, 199) == 0) begin
            rx_calm <= !rx_calm;
        end
        if (rx_hold != 0) begin
            m_tready <= 1'b0;
            rx_hold  <= rx_hold - 1;
        end else begin
            m_tready <= 1'b1;
            rx_hold  <= pick_gap(rx_calm);
        end
    end

    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.mode    = mode_t'(m_tdata[1:0]);
            got.frames  = m_tdata[9:2];
            got.end_sec = m_tdata[42:10];
            if (status_due.size() == 0) begin
                note_failure($sformatf("unexpected result word mode %0d frames %0d end %0d",
                                       got.mode, got.frames, got.end_sec));
            end else begin
                want = status_due.pop_front();
                if (got.mode !== want.mode || got.frames !== want.frames ||
                    got.end_sec !== want.end_sec) begin
                    note_failure($sformatf({"mismatch: expected mode %0d frames %0d end %0d,",
                                            " got mode %0d frames %0d end %0d"},
                                           want.mode, want.frames, want.end_sec,
                                           got.mode, got.frames, got.end_sec));
                end
            end
        end
    end

    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                (cfg_valid && cfg_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        logic [31:0] sec_clk;
        logic [47:0] us_clk;
        logic [23:0] level;
        op_t         op;
        int          r;
        cfg_shadow   = '{threshold: 24'd1000, needed: 8'd3, lifetime: 16'd1,
                         pre_delay: 16'd0, post_delay: 16'd0,
                         min_trig: 16'd5, max_trig: 16'd60};
        alarm_mode   = MODE_IDLE;
        hit_count    = '0;
        wake_at      = '0;
        trig_start   = '0;
        seg_end      = '0;
        win_start_us = '0;

        // reset configuration: threshold 1000, three frames in one second,
        // trigger lasts five seconds past motion, capped at sixty
        add_row(OP_FRAME, 32'd100, 48'd0,    24'd0,    1, MODE_WAITING,  8'd0, 33'd0);
        add_row(OP_FRAME, 32'd100, 48'd500,  24'd0,    1, MODE_WAITING,  8'd0, 33'd0);
        add_row(OP_FRAME, 32'd101, 48'd800,  24'd0,    1, MODE_VIGILANT, 8'd0, 33'd0);
        add_row(OP_FRAME, 32'd101, 48'd1000, 24'd1000, 1, MODE_VIGILANT, 8'd0, 33'd0);
        add_row(OP_FRAME, 32'd101, 48'd2000, 24'd1001, 0, MODE_IDLE,     8'd0, 33'd0);
        add_row(OP_FRAME, 32'd101, 48'd3000, 24'hFFFFFF, 0, MODE_IDLE,   8'd0, 33'd0);
        add_row(OP_FRAME, 32'd102, 48'd5000, 24'hFFFFFF, 1, MODE_TRIGGERED, 8'd0, 33'd107);
        add_row(OP_FRAME, 32'd105, 48'd9000, 24'd1001, 1, MODE_TRIGGERED, 8'd0, 33'd110);
        add_row(OP_FRAME, 32'd111, 48'd9500, 24'd0,    1, MODE_WAITING,  8'd0, 33'd110);
        add_row(OP_FRAME, 32'd112, 48'd9600, 24'd0,    0, MODE_IDLE,     8'd0, 33'd0);
        // clock wraps inside the window, then the window runs out
        add_row(OP_FRAME, 32'd112, 48'hFFFF_FFFF_FF9C, 24'd5000, 0, MODE_IDLE, 8'd0, 33'd0);
        add_row(OP_FRAME, 32'd112, 48'd500,  24'd5000, 0, MODE_IDLE,     8'd0, 33'd0);
        add_row(OP_FRAME, 32'd113, 48'd2000000, 24'd5000, 1, MODE_VIGILANT, 8'd0, 33'd0);
        add_row(OP_RESET, 32'hFFFFFFFF, 48'hFFFF_FFFF_FFFF, 24'hFFFFFF, 1, MODE_IDLE,
                8'd0, 33'd0);
        add_row(OP_FRAME, 32'hFFFFFFFF, 48'hFFFF_FFFF_FFFF, 24'hFFFFFF, 1, MODE_WAITING,
                8'd0, 33'd0);
        add_row(OP_FRAME, 32'hFFFFFFFF, 48'd0, 24'd0, 1, MODE_WAITING, 8'd0, 33'd0);
        add_row(OP_FRAME, 32'd0, 48'd1, 24'd1, 1, MODE_WAITING, 8'd0, 33'd0);
        add_row(OP_RESET, 32'd0, 48'd0, 24'd0, 1, MODE_IDLE, 8'd0, 33'd0);

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (frame_table[i]) begin
            send_word(op_t'(frame_table[i].op), frame_table[i].sec, frame_table[i].usec,
                      frame_table[i].level, frame_table[i].typed, frame_table[i].want);
        end

        for (int p = 0; p < PHASES; p++) begin
            drain_results();
            configure_phase(p);
            case ($urandom_range(0, 2))
                0:       sec_clk = $urandom_range(0, 1000);
                1:       sec_clk = $urandom;
                default: sec_clk = 32'hFFFFFFFF - $urandom_range(0, 300);
            endcase
            us_clk = ($urandom_range(0, 1) == 0) ? 48'({16'($urandom), $urandom})
                                                 : 48'hFFFF_FFFF_FFFF - 48'($urandom_range(0, 99999));
            for (int n = 0; n < PHASE_FRAMES; n++) begin
                if ($urandom_range(0, 99) == 0) begin
                    drain_results();
                end
                r = $urandom_range(0, 99);
                if (r < 8) begin
                    op = op_t'($urandom_range(0, 1));
                    send_word(op, $urandom, 48'({16'($urandom), $urandom}),
                              24'($urandom), 0, '0);
                end else if (r < 10) begin
                    send_word(OP_RESET, sec_clk, us_clk, pick_level($urandom_range(0, 1)), 0, '0);
                end else begin
                    r = $urandom_range(0, 99);
                    if (r < 70) begin
                        sec_clk = sec_clk;
                    end else if (r < 95) begin
                        sec_clk = sec_clk + 32'd1;
                    end else if (r < 99) begin
                        sec_clk = sec_clk + $urandom_range(2, 20);
                    end else begin
                        sec_clk = sec_clk + $urandom_range(1, 70000);
                    end
                    if ($urandom_range(0, 9) == 0) begin
                        us_clk = us_clk + 48'($urandom_range(0, 3000000));
                    end else begin
                        us_clk = us_clk + 48'($urandom_range(20000, 60000));
                    end
                    level = pick_level($urandom_range(0, 99) < 55);
                    send_word(OP_FRAME, sec_clk, us_clk, level, 0, '0);
                end
            end
        end

        drain_results();
        repeat (10) @(posedge aclk);
        if (status_due.size() != 0) begin
            note_failure("results still outstanding at end of run");
        end
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/mat_pkg.sv
hw/rtl/mat_front.sv
hw/rtl/mat_queue.sv
hw/rtl/mat_back.sv
hw/rtl/motion_alarm_trigger_fsm_unit.sv
hw/rtl/mat_checker.sv
test/tb_top.sv
